// File: design/sst_pkg.sv
package sst_pkg;

  // Table geometry
  localparam int MAX_ENTITIES = 256;
  localparam int CAPACITY     = 256;
  localparam int VAL_W        = 32;
  localparam int ENT_W        = $clog2(MAX_ENTITIES);
  localparam int SLOT_W       = $clog2(CAPACITY);
  localparam int CNT_W        = SLOT_W + 1;
  localparam int OP_W         = 3;
  localparam int STATUS_W     = 2;

  // Operation codes
  typedef enum logic [OP_W-1:0] {
    OP_HAS    = 3'd0,
    OP_GET    = 3'd1,
    OP_SET    = 3'd2,
    OP_ADD    = 3'd3,
    OP_REMOVE = 3'd4
  } op_e;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    STAT_OK      = 2'd0,
    STAT_NULL_ID = 2'd1,
    STAT_FULL    = 2'd2
  } status_e;

  // Sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOK,
    S_GET,
    S_MOVE
  } state_e;

  // Memory requests from the sequencer
  typedef struct packed {
    logic              slot_we;
    logic [ENT_W-1:0]  slot_waddr;
    logic [SLOT_W-1:0] slot_wdata;
    logic [ENT_W-1:0]  slot_raddr;
    logic              owner_we;
    logic [SLOT_W-1:0] owner_waddr;
    logic [ENT_W-1:0]  owner_wdata;
    logic [SLOT_W-1:0] owner_raddr;
    logic              dense_we;
    logic [SLOT_W-1:0] dense_waddr;
    logic [VAL_W-1:0]  dense_wdata;
    logic [SLOT_W-1:0] dense_raddr;
  } mem_req_t;

  // Registered read data back from the memories
  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic [ENT_W-1:0]  owner;
    logic [VAL_W-1:0]  dense;
  } mem_rsp_t;

  // One result item
  typedef struct packed {
    logic                done;
    logic                present;
    logic [VAL_W-1:0]    read_value;
    logic [STATUS_W-1:0] status;
    logic [CNT_W-1:0]    count;
  } result_t;

endpackage

// File: design/sst_ram.sv
module sst_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/sst_ctrl.sv
module sst_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [sst_pkg::OP_W-1:0]      op_i,
  input  logic [sst_pkg::ENT_W-1:0]     entity_i,
  input  logic [sst_pkg::VAL_W-1:0]     value_i,
  input  logic [sst_pkg::VAL_W-1:0]     null_value_i,
  input  sst_pkg::mem_rsp_t             rsp_i,
  output sst_pkg::mem_req_t             req_o,
  output logic                          busy_o,
  output sst_pkg::result_t              res_o
);

  import sst_pkg::*;

  state_e               state_q, state_d;
  logic [OP_W-1:0]      op_q, op_d;
  logic [ENT_W-1:0]     ent_q, ent_d;
  logic [VAL_W-1:0]     val_q, val_d;
  logic [SLOT_W-1:0]    hole_q, hole_d;
  logic [CNT_W-1:0]     used_q, used_d;
  logic [MAX_ENTITIES-1:0] valid_q;
  logic                 valid_set, valid_clr;
  logic                 done_q, done_d;
  logic                 present_q, present_d;
  logic [VAL_W-1:0]     rd_q, rd_d;
  logic [STATUS_W-1:0]  status_q, status_d;
  logic                 present;
  logic [SLOT_W-1:0]    last;
  logic [VAL_W-1:0]     put_val;
  logic [CNT_W-1:0]     used_dec;

  assign present  = valid_q[ent_q];
  assign used_dec = used_q - CNT_W'(1);
  assign last     = used_dec[SLOT_W-1:0];
  assign put_val  = (op_q == OP_SET) ? val_q : null_value_i;

  // Sequence one item: look up the slot, then read or modify the tables
  always_comb begin
    state_d   = state_q;
    op_d      = op_q;
    ent_d     = ent_q;
    val_d     = val_q;
    hole_d    = hole_q;
    used_d    = used_q;
    valid_set = 1'b0;
    valid_clr = 1'b0;
    done_d    = 1'b0;
    present_d = present_q;
    rd_d      = rd_q;
    status_d  = status_q;

    req_o             = '0;
    req_o.slot_raddr  = entity_i;
    req_o.owner_raddr = last;
    req_o.dense_raddr = (op_q == OP_GET) ? rsp_i.slot : last;

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          op_d    = op_i;
          ent_d   = entity_i;
          val_d   = value_i;
          state_d = S_LOOK;
        end
      end

      S_LOOK: begin
        present_d = present;
        status_d  = STAT_OK;
        rd_d      = '0;
        done_d    = 1'b1;
        state_d   = S_IDLE;
        if (ent_q == '0) begin
          // Null entity: no effect
          present_d = 1'b0;
          status_d  = STAT_NULL_ID;
          if (op_q == OP_GET) begin
            rd_d = null_value_i;
          end
        end else begin
          case (op_q)
            OP_GET: begin
              if (present) begin
                done_d  = 1'b0;
                state_d = S_GET;
              end else begin
                rd_d = null_value_i;
              end
            end

            OP_SET, OP_ADD: begin
              if (present) begin
                // Overwrite in place
                req_o.dense_we    = 1'b1;
                req_o.dense_waddr = rsp_i.slot;
                req_o.dense_wdata = put_val;
              end else if (used_q == CNT_W'(CAPACITY)) begin
                status_d = STAT_FULL;
              end else begin
                // Append at the end of the dense array
                req_o.dense_we    = 1'b1;
                req_o.dense_waddr = used_q[SLOT_W-1:0];
                req_o.dense_wdata = put_val;
                req_o.owner_we    = 1'b1;
                req_o.owner_waddr = used_q[SLOT_W-1:0];
                req_o.owner_wdata = ent_q;
                req_o.slot_we     = 1'b1;
                req_o.slot_waddr  = ent_q;
                req_o.slot_wdata  = used_q[SLOT_W-1:0];
                valid_set         = 1'b1;
                used_d            = used_q + CNT_W'(1);
              end
            end

            OP_REMOVE: begin
              if (present) begin
                if (rsp_i.slot == last) begin
                  // Last slot: just pop
                  valid_clr = 1'b1;
                  used_d    = used_dec;
                end else begin
                  // Fetch the last entry and its owner for the swap
                  hole_d  = rsp_i.slot;
                  done_d  = 1'b0;
                  state_d = S_MOVE;
                end
              end
            end

            default: begin
            end
          endcase
        end
      end

      S_GET: begin
        rd_d    = rsp_i.dense;
        done_d  = 1'b1;
        state_d = S_IDLE;
      end

      S_MOVE: begin
        // Move the last entry into the hole and repoint its owner
        req_o.dense_we    = 1'b1;
        req_o.dense_waddr = hole_q;
        req_o.dense_wdata = rsp_i.dense;
        req_o.owner_we    = 1'b1;
        req_o.owner_waddr = hole_q;
        req_o.owner_wdata = rsp_i.owner;
        req_o.slot_we     = 1'b1;
        req_o.slot_waddr  = rsp_i.owner;
        req_o.slot_wdata  = hole_q;
        valid_clr         = 1'b1;
        used_d            = used_dec;
        done_d            = 1'b1;
        state_d           = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      used_q  <= '0;
      valid_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      used_q  <= used_d;
      done_q  <= done_d;
      if (valid_set) begin
        valid_q[ent_q] <= 1'b1;
      end else if (valid_clr) begin
        valid_q[ent_q] <= 1'b0;
      end
    end
  end

  // Item and result payload
  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    ent_q     <= ent_d;
    val_q     <= val_d;
    hole_q    <= hole_d;
    present_q <= present_d;
    rd_q      <= rd_d;
    status_q  <= status_d;
  end

  assign busy_o             = (state_q != S_IDLE);
  assign res_o.done         = done_q;
  assign res_o.present      = present_q;
  assign res_o.read_value   = rd_q;
  assign res_o.status       = status_q;
  assign res_o.count        = used_q;

endmodule

// File: design/sparse_set_component_table_unit.sv
// Channel  | Ports                                    | Handshake
// ---------+------------------------------------------+----------------------------
// in       | op_i, entity_i, value_i                  | start_i high, busy_o low
// out      | present_o, read_value_o, status_o, count_o | done_o high for one cycle
// cfg      | cfg_wdata_i (null value)                 | cfg_we_i high
//
// An item is accepted, its slot is read from the slot memory, and then the
// result is shown while the next item can already be taken. A get of a present
// entity and a remove that swaps in the last entry also pass through S_GET or
// S_MOVE for a second read, of the value memory and, for the remove, of the
// owner memory. Reset clears the valid bits and the count; no clearing pass.
// done_o is never stalled: the receiver must take each result in its cycle.
module sparse_set_component_table_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [sst_pkg::OP_W-1:0]      op_i,
  input  logic [sst_pkg::ENT_W-1:0]     entity_i,
  input  logic [sst_pkg::VAL_W-1:0]     value_i,
  output logic                          done_o,
  output logic                          present_o,
  output logic [sst_pkg::VAL_W-1:0]     read_value_o,
  output logic [sst_pkg::STATUS_W-1:0]  status_o,
  output logic [sst_pkg::CNT_W-1:0]     count_o,
  input  logic                          cfg_we_i,
  input  logic [sst_pkg::VAL_W-1:0]     cfg_wdata_i
);

  import sst_pkg::*;

  logic [VAL_W-1:0] null_value_q;
  mem_req_t         req;
  mem_rsp_t         rsp;
  result_t          res;

  // Null value register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      null_value_q <= '0;
    end else if (cfg_we_i) begin
      null_value_q <= cfg_wdata_i;
    end
  end

  sst_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .op_i         (op_i),
    .entity_i     (entity_i),
    .value_i      (value_i),
    .null_value_i (null_value_q),
    .rsp_i        (rsp),
    .req_o        (req),
    .busy_o       (busy_o),
    .res_o        (res)
  );

  // Entity to slot map
  sst_ram #(.WIDTH(SLOT_W), .DEPTH(MAX_ENTITIES)) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (req.slot_we),
    .waddr_i (req.slot_waddr),
    .wdata_i (req.slot_wdata),
    .raddr_i (req.slot_raddr),
    .rdata_o (rsp.slot)
  );

  // Slot to owner reverse index
  sst_ram #(.WIDTH(ENT_W), .DEPTH(CAPACITY)) u_owner_ram (
    .clk_i   (clk_i),
    .we_i    (req.owner_we),
    .waddr_i (req.owner_waddr),
    .wdata_i (req.owner_wdata),
    .raddr_i (req.owner_raddr),
    .rdata_o (rsp.owner)
  );

  // Dense value array
  sst_ram #(.WIDTH(VAL_W), .DEPTH(CAPACITY)) u_dense_ram (
    .clk_i   (clk_i),
    .we_i    (req.dense_we),
    .waddr_i (req.dense_waddr),
    .wdata_i (req.dense_wdata),
    .raddr_i (req.dense_raddr),
    .rdata_o (rsp.dense)
  );

  assign done_o       = res.done;
  assign present_o    = res.present;
  assign read_value_o = res.read_value;
  assign status_o     = res.status;
  assign count_o      = res.count;

endmodule

// File: design/sst_checker.sv
module sst_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          start_i,
  input logic                          busy_o,
  input logic                          done_o,
  input logic                          present_o,
  input logic [sst_pkg::STATUS_W-1:0]  status_o,
  input logic [sst_pkg::CNT_W-1:0]     count_o
);

  import sst_pkg::*;

  // Accepted item makes the unit busy next cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o)
    else $error("item accepted but unit not busy");

  // A result is shown only once the unit is free again
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("result shown while busy");

  // Count never exceeds the capacity
  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_o <= CNT_W'(CAPACITY))
    else $error("count above capacity");

  // Null entity is never reported present, and status stays a known code
  a_null_absent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (status_o == STAT_NULL_ID) |-> !present_o)
    else $error("null entity reported present");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (status_o == STAT_OK) || (status_o == STAT_NULL_ID) ||
               (status_o == STAT_FULL))
    else $error("unknown status code");

endmodule

bind sparse_set_component_table_unit sst_checker u_sst_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .start_i   (start_i),
  .busy_o    (busy_o),
  .done_o    (done_o),
  .present_o (present_o),
  .status_o  (status_o),
  .count_o   (count_o)
);
